FILE: design/pcs_pkg.sv
// Shared types and constants for the piecewise-constant sampler.
// No dependencies; used by pcs_div and piecewise_constant_sampler.
package pcs_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PROD_W  = 2 * DATA_W;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned ENTRY_W = 4;
  localparam int unsigned IIDX_W  = 3;
  localparam int unsigned DIV_CNT_W = $clog2(DATA_W + 1);

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_RD   = 10'b00_0000_0010,
    S_CMP  = 10'b00_0000_0100,
    S_LO   = 10'b00_0000_1000,
    S_HI   = 10'b00_0001_0000,
    S_WID  = 10'b00_0010_0000,
    S_MUL  = 10'b00_0100_0000,
    S_DST  = 10'b00_1000_0000,
    S_DIV  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_t;

endpackage

FILE: design/pcs_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// Requires dividend[63:32] < divisor. Depends on pcs_pkg.
module pcs_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pcs_pkg::PROD_W-1:0]   dividend,
  input  logic [pcs_pkg::DATA_W-1:0]   divisor,
  output logic                         done,
  output logic [pcs_pkg::DATA_W-1:0]   quotient
);

  logic [pcs_pkg::DATA_W-1:0]    rem;
  logic [pcs_pkg::DATA_W-1:0]    shq;
  logic [pcs_pkg::DIV_CNT_W-1:0] cnt;
  logic                          busy;
  logic [pcs_pkg::DATA_W:0]      trial;
  logic [pcs_pkg::DATA_W:0]      diff;
  logic                          qbit;

  always_comb begin
    trial = {rem, shq[pcs_pkg::DATA_W-1]};
    diff  = trial - {1'b0, divisor};
    qbit  = !diff[pcs_pkg::DATA_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= pcs_pkg::DIV_CNT_W'(pcs_pkg::DATA_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == pcs_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[pcs_pkg::PROD_W-1:pcs_pkg::DATA_W];
      shq <= dividend[pcs_pkg::DATA_W-1:0];
    end else if (busy) begin
      rem <= qbit ? diff[pcs_pkg::DATA_W-1:0] : trial[pcs_pkg::DATA_W-1:0];
      shq <= {shq[pcs_pkg::DATA_W-2:0], qbit};
    end
  end

  assign quotient = shq;

endmodule

FILE: design/piecewise_constant_sampler.sv
// Top level of the piecewise-constant inverse-CDF sampler.
// Depends on pcs_pkg and pcs_div.
//
// Input channel (in_valid/in_ready): a beat with cmd = write stores break_value
// and prob_value at entry_index (prob is dropped at the last break index, and
// an index above MAX_INTERVALS writes nothing). A beat with cmd = sample takes
// the uniform draw p_value and returns one beat on the output channel
// (out_valid/out_ready) with sample_value, interval_index and status.
// Write beats return nothing and keep in_ready high.
// A sample that lands in interval k raises out_valid after the probability scan
// (states S_RD and S_CMP for each interval up to k), the break-point reads and
// width set-up (S_LO, S_HI, S_WID), the multiply (S_MUL), the divider start
// (S_DST), the bit-serial divider (S_DIV) and the output load (S_DONE).
// A draw not below the total probability returns status 1 after the scan. One
// sample is in flight at a time; in_ready is low from acceptance until the
// result is loaded, so the next beat can be taken in the cycle after the load.
// A finished beat waits in the output register while the receiver stalls, and
// a second result waits too. num_intervals is set through cfg_wr_en/cfg_wr_data;
// the user must write it only while idle, which the block does not enforce.
// Reset clears control state and sets num_intervals to 1; tables are unset.
module piecewise_constant_sampler #(
  parameter int unsigned MAX_INTERVALS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [pcs_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               cmd,
  input  logic [pcs_pkg::ENTRY_W-1:0]        entry_index,
  input  logic [pcs_pkg::DATA_W-1:0]         prob_value,
  input  logic signed [pcs_pkg::DATA_W-1:0]  break_value,
  input  logic [pcs_pkg::DATA_W-1:0]         p_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pcs_pkg::DATA_W-1:0]  sample_value,
  output logic [pcs_pkg::IIDX_W-1:0]         interval_index,
  output logic                               status
);

  localparam int unsigned IDX_W = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned PA_W  = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned SUM_W = pcs_pkg::DATA_W + IDX_W;
  localparam int unsigned W     = pcs_pkg::DATA_W;

  logic [W-1:0] prob_mem [MAX_INTERVALS];
  logic [W-1:0] brk_mem  [MAX_INTERVALS + 1];

  pcs_pkg::state_t state;

  logic [pcs_pkg::CFG_W-1:0] num_intervals;
  logic [IDX_W-1:0]          n_use;
  logic [IDX_W-1:0]          idx;
  logic [W-1:0]              p_reg;
  logic [SUM_W-1:0]          sum;
  logic [SUM_W-1:0]          sum_next;
  logic [W-1:0]              prob_rd;
  logic [W-1:0]              brk_rd;
  logic [IDX_W-1:0]          brk_addr;
  logic [W-1:0]              rem;
  logic [W-1:0]              pr;
  logic [W-1:0]              lo;
  logic [W:0]                wid;
  logic                      neg;
  logic [W-1:0]              aw;
  logic [pcs_pkg::PROD_W-1:0] prod;
  logic                      div_start;
  logic                      div_done;
  logic [W-1:0]              quo;
  logic [W-1:0]              res_sample;
  logic [pcs_pkg::IIDX_W-1:0] res_idx;
  logic                      res_status;
  logic                      accept;
  logic                      load_out;

  assign in_ready  = (state == pcs_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign div_start = (state == pcs_pkg::S_DST);
  assign load_out  = (state == pcs_pkg::S_DONE) && (!out_valid || out_ready);
  assign sum_next  = sum + SUM_W'(prob_rd);
  assign brk_addr  = (state == pcs_pkg::S_LO) ? idx : idx + 1'b1;
  assign wid       = {brk_rd[W-1], brk_rd} - {lo[W-1], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      num_intervals <= pcs_pkg::CFG_W'(1);
    end else if (cfg_wr_en) begin
      num_intervals <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == pcs_pkg::CMD_WRITE) begin
      if (32'(entry_index) <= MAX_INTERVALS) begin
        brk_mem[IDX_W'(entry_index)] <= break_value;
      end
      if (32'(entry_index) < MAX_INTERVALS) begin
        prob_mem[PA_W'(entry_index)] <= prob_value;
      end
    end
    if (state == pcs_pkg::S_RD && idx < n_use) begin
      prob_rd <= prob_mem[PA_W'(idx)];
    end
    if (state == pcs_pkg::S_LO || state == pcs_pkg::S_HI) begin
      brk_rd <= brk_mem[brk_addr];
    end
  end

  pcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (pr),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pcs_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        pcs_pkg::S_IDLE: begin
          if (accept && cmd == pcs_pkg::CMD_SAMPLE) begin
            state <= pcs_pkg::S_RD;
          end
        end
        pcs_pkg::S_RD: begin
          state <= (idx < n_use) ? pcs_pkg::S_CMP : pcs_pkg::S_DONE;
        end
        pcs_pkg::S_CMP: begin
          state <= (SUM_W'(p_reg) < sum_next) ? pcs_pkg::S_LO : pcs_pkg::S_RD;
        end
        pcs_pkg::S_LO:  state <= pcs_pkg::S_HI;
        pcs_pkg::S_HI:  state <= pcs_pkg::S_WID;
        pcs_pkg::S_WID: state <= pcs_pkg::S_MUL;
        pcs_pkg::S_MUL: state <= pcs_pkg::S_DST;
        pcs_pkg::S_DST: state <= pcs_pkg::S_DIV;
        pcs_pkg::S_DIV: begin
          if (div_done) begin
            state <= pcs_pkg::S_DONE;
          end
        end
        pcs_pkg::S_DONE: begin
          if (load_out) begin
            state <= pcs_pkg::S_IDLE;
          end
        end
        default: state <= pcs_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pcs_pkg::S_IDLE: begin
        p_reg <= p_value;
        sum   <= '0;
        idx   <= '0;
        if (32'(num_intervals) > MAX_INTERVALS) begin
          n_use <= IDX_W'(MAX_INTERVALS);
        end else begin
          n_use <= IDX_W'(num_intervals);
        end
      end
      pcs_pkg::S_RD: begin
        if (idx >= n_use) begin
          res_sample <= '0;
          res_idx    <= '0;
          res_status <= pcs_pkg::ST_RANGE;
        end
      end
      pcs_pkg::S_CMP: begin
        if (SUM_W'(p_reg) < sum_next) begin
          rem <= W'(SUM_W'(p_reg) - sum);
          pr  <= prob_rd;
        end else begin
          sum <= sum_next;
          idx <= idx + 1'b1;
        end
      end
      pcs_pkg::S_HI: begin
        lo <= brk_rd;
      end
      pcs_pkg::S_WID: begin
        neg <= wid[W];
        aw  <= wid[W] ? W'(-wid) : wid[W-1:0];
      end
      pcs_pkg::S_MUL: begin
        prod <= rem * aw;
      end
      pcs_pkg::S_DIV: begin
        if (div_done) begin
          res_sample <= neg ? lo - quo : lo + quo;
          res_idx    <= pcs_pkg::IIDX_W'(idx);
          res_status <= pcs_pkg::ST_OK;
        end
      end
      pcs_pkg::S_DONE: begin
        if (load_out) begin
          sample_value   <= res_sample;
          interval_index <= res_idx;
          status         <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == pcs_pkg::ST_RANGE) |-> (sample_value == '0 && interval_index == '0))
    else $error("range result carries nonzero payload");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == pcs_pkg::S_DIV))
    else $error("divider finished outside its state");

  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == pcs_pkg::CMD_SAMPLE) |=> (state == pcs_pkg::S_RD && !in_ready))
    else $error("sample beat did not start the scan");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == pcs_pkg::CMD_WRITE) |=> (state == pcs_pkg::S_IDLE))
    else $error("write beat left the idle state");

endmodule

FILE: sim/tb_piecewise_constant_sampler.sv
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_constant_sampler: directed table, interval-count
// and edge-value cases, output backpressure, then random traffic under input idling and output stalls.
// Depends on pcs_pkg and the piecewise_constant_sampler RTL.
module tb_piecewise_constant_sampler;

  localparam int unsigned NUM_IVL      = 8;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 4000;

  typedef struct packed {
    logic signed [pcs_pkg::DATA_W-1:0] value;
    logic [pcs_pkg::IIDX_W-1:0]        ivl;
    logic                              status;
  } sample_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_wr_en = 1'b0;
  logic [pcs_pkg::CFG_W-1:0]           cfg_wr_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                cmd = pcs_pkg::CMD_WRITE;
  logic [pcs_pkg::ENTRY_W-1:0]         entry_index = '0;
  logic [pcs_pkg::DATA_W-1:0]          prob_value = '0;
  logic signed [pcs_pkg::DATA_W-1:0]   break_value = '0;
  logic [pcs_pkg::DATA_W-1:0]          p_value = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [pcs_pkg::DATA_W-1:0]   sample_value;
  logic [pcs_pkg::IIDX_W-1:0]          interval_index;
  logic                                status;

  logic signed [pcs_pkg::DATA_W-1:0]   break_mem [0:NUM_IVL];
  logic [pcs_pkg::DATA_W-1:0]          prob_mem [0:NUM_IVL-1];
  logic [pcs_pkg::CFG_W-1:0]           active_intervals = 4'd1;
  sample_t                             expected_samples [$];
  int unsigned                         mismatches = 0;
  int unsigned                         quiet_cycles = 0;
  int unsigned                         send_idle_pct = 0;
  int unsigned                         stall_pct = 0;
  logic                                hold_req = 1'b0;

  piecewise_constant_sampler #(.MAX_INTERVALS(NUM_IVL)) DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .entry_index(entry_index), .prob_value(prob_value),
    .break_value(break_value), .p_value(p_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .sample_value(sample_value), .interval_index(interval_index), .status(status)
  );

  always #5 clk = ~clk;

  function automatic sample_t predict_sample(input logic [pcs_pkg::DATA_W-1:0] p);
    sample_t                     r;
    logic [39:0]                 run_sum;
    logic [pcs_pkg::DATA_W-1:0]  rem;
    logic signed [33:0]          lo, hi, w;
    logic [32:0]                 aw;
    logic [63:0]                 prod, quot;
    logic [33:0]                 s;
    int                          n, i;
    n = (active_intervals > NUM_IVL) ? int'(NUM_IVL) : int'(active_intervals);
    r.value = '0;
    r.ivl = '0;
    r.status = pcs_pkg::ST_RANGE;
    run_sum = '0;
    for (i = 0; i < n; i++) begin
      if ({8'b0, p} < run_sum + {8'b0, prob_mem[i]}) begin
        rem = p - run_sum[31:0];
        lo = 34'(break_mem[i]);
        hi = 34'(break_mem[i+1]);
        w = hi - lo;
        aw = 33'((w < 0) ? -w : w);
        prod = rem * aw;
        quot = prod / {32'b0, prob_mem[i]};
        s = (w < 0) ? lo - quot[33:0] : lo + quot[33:0];
        r.value = s[31:0];
        r.ivl = i[pcs_pkg::IIDX_W-1:0];
        r.status = pcs_pkg::ST_OK;
        return r;
      end
      run_sum = run_sum + {8'b0, prob_mem[i]};
    end
    return r;
  endfunction

  // Track the register, predict on input beats, check output beats.
  always @(posedge clk) begin
    sample_t exp_s;
    if (rst) begin
      active_intervals = 4'd1;
    end else begin
      if (cfg_wr_en) active_intervals = cfg_wr_data;
      if (in_valid && in_ready) begin
        if (cmd == pcs_pkg::CMD_WRITE) begin
          if (entry_index <= NUM_IVL) begin
            break_mem[entry_index] = break_value;
            if (entry_index < NUM_IVL)
              prob_mem[entry_index[$clog2(NUM_IVL)-1:0]] = prob_value;
          end
        end else begin
          expected_samples.push_back(predict_sample(p_value));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t unexpected beat: value %0d interval %0d status %0d",
                   $time, sample_value, interval_index, status);
          mismatches++;
        end else begin
          exp_s = expected_samples.pop_front();
          if (sample_value !== exp_s.value) begin
            $display("%0t sample_value: expected %0d, got %0d",
                     $time, exp_s.value, sample_value);
            mismatches++;
          end
          if (interval_index !== exp_s.ivl) begin
            $display("%0t interval_index: expected %0d, got %0d",
                     $time, exp_s.ivl, interval_index);
            mismatches++;
          end
          if (status !== exp_s.status) begin
            $display("%0t status: expected %0d, got %0d", $time, exp_s.status, status);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[piecewise_constant_sampler] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, or one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Call at a falling edge; returns at the falling edge after the beat.
  task automatic send_beat(input logic c, input logic [pcs_pkg::ENTRY_W-1:0] idx,
                           input logic [pcs_pkg::DATA_W-1:0] prob,
                           input logic [pcs_pkg::DATA_W-1:0] brk,
                           input logic [pcs_pkg::DATA_W-1:0] p);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    cmd <= c;
    entry_index <= idx;
    prob_value <= prob;
    break_value <= brk;
    p_value <= p;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_intervals(input logic [pcs_pkg::CFG_W-1:0] n);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic sample_at(input logic [pcs_pkg::DATA_W-1:0] p);
    send_beat(pcs_pkg::CMD_SAMPLE, pcs_pkg::ENTRY_W'($urandom_range(15)),
              $urandom, $urandom, p);
  endtask

  // Reset value of one interval; fill every entry, probe both sides of the total.
  task automatic test_first_interval();
    int i;
    send_beat(pcs_pkg::CMD_WRITE, 4'd0, 32'h8000_0000, 32'sd0, $urandom);
    for (i = 1; i <= NUM_IVL; i++)
      send_beat(pcs_pkg::CMD_WRITE, pcs_pkg::ENTRY_W'(i),
                (i == NUM_IVL) ? 32'hFFFF_FFFF : 32'h1000_0000, i << 16, $urandom);
    send_beat(pcs_pkg::CMD_WRITE, 4'd15, 32'hFFFF_FFFF, 32'h7FFF_FFFF, $urandom);
    sample_at(32'h0000_0000);
    sample_at(32'h7FFF_FFFF);
    sample_at(32'h8000_0000);
    sample_at(32'hFFFF_FFFF);
  endtask

  // All intervals, none, saturated count, and a zero-probability interval.
  task automatic test_interval_count();
    set_intervals(4'd8);
    sample_at(32'hEFFF_FFFF);
    sample_at(32'hF000_0000);
    set_intervals(4'd0);
    sample_at(32'h0000_0000);
    set_intervals(4'd15);
    sample_at(32'hEFFF_FFFF);
    send_beat(pcs_pkg::CMD_WRITE, 4'd2, 32'h0000_0000, 32'sd2 << 16, $urandom);
    sample_at(32'h9000_0000);
  endtask

  // Full-range width in both directions with the largest probability.
  task automatic test_edge_values();
    set_intervals(4'd1);
    send_beat(pcs_pkg::CMD_WRITE, 4'd0, 32'hFFFF_FFFF, 32'h8000_0000, $urandom);
    send_beat(pcs_pkg::CMD_WRITE, 4'd1, 32'h0000_0000, 32'h7FFF_FFFF, $urandom);
    sample_at(32'hFFFF_FFFE);
    send_beat(pcs_pkg::CMD_WRITE, 4'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, $urandom);
    send_beat(pcs_pkg::CMD_WRITE, 4'd1, 32'h0000_0000, 32'h8000_0000, $urandom);
    sample_at(32'hFFFF_FFFE);
    sample_at(32'h0000_0001);
  endtask

  // Hold the receiver off while samples keep coming, so the input stalls.
  task automatic test_output_backpressure();
    int i;
    set_intervals(4'd8);
    send_idle_pct = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    for (i = 0; i < 10; i++) sample_at($urandom);
    settle();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall,
                                     input int unsigned beats);
    int unsigned               sent, eff, k, j, i;
    logic [pcs_pkg::CFG_W-1:0] n;
    logic [39:0]               total;
    logic [31:0]               prob, brk, p;
    logic [3:0]                idx;
    bit                        wild;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(4) != 0) n = pcs_pkg::CFG_W'($urandom_range(1, NUM_IVL));
      else n = $urandom_range(1) ? 4'd0 : pcs_pkg::CFG_W'($urandom_range(NUM_IVL + 1, 15));
      set_intervals(n);
      eff = (n > NUM_IVL) ? NUM_IVL : n;
      wild = ($urandom_range(9) == 0);
      total = '0;
      brk = $urandom;
      for (i = 0; i <= eff; i++) begin
        if (wild) prob = $urandom;
        else if ($urandom_range(9) == 0) prob = '0;
        else prob = $urandom_range(0, 32'hFFFF_FFFF / ((eff == 0) ? 1 : eff));
        if (i < eff) total += prob;
        send_beat(pcs_pkg::CMD_WRITE, pcs_pkg::ENTRY_W'(i), prob, wild ? $urandom : brk,
                  $urandom);
        brk = brk + $urandom_range(0, 32'h0FFF_FFFF);
        sent++;
      end
      k = $urandom_range(8, 24);
      for (j = 0; j < k; j++) begin
        if ($urandom_range(9) == 0) begin
          idx = pcs_pkg::ENTRY_W'($urandom_range(15));
          send_beat(pcs_pkg::CMD_WRITE, idx, $urandom, $urandom, $urandom);
          if (idx <= NUM_IVL) sent++;
        end else begin
          if (total != 0 && $urandom_range(3) != 0)
            p = (total > 40'hFFFF_FFFF) ? $urandom : $urandom_range(0, total[31:0] - 1);
          else
            p = $urandom;
          sample_at(p);
          sent++;
        end
      end
    end
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_first_interval();
    test_interval_count();
    test_edge_values();
    test_output_backpressure();
    test_random_traffic(0, 0, 190);
    test_random_traffic(73, 0, 190);
    test_random_traffic(0, 73, 190);
    test_random_traffic(23, 23, 190);
    settle();
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("[piecewise_constant_sampler] OK");
    end else begin
      $display("[piecewise_constant_sampler] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
design/pcs_pkg.sv
design/pcs_div.sv
design/piecewise_constant_sampler.sv
sim/tb_piecewise_constant_sampler.sv
